// File: hdl/assert_macros.svh
// Assertion shorthands shared by the RTL files.
// Each use needs clk in scope; SKT_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SKT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sktbl_pkg.sv
package sktbl_pkg;

  localparam int KeyW   = 64;
  localparam int FidW   = 32;
  localparam int StatW  = 2;
  localparam int UsedW  = 7;

  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_FULL = 2'd1;
  localparam logic [StatW-1:0] ST_DUP  = 2'd2;

  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_QUERY    = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            permit;
    logic [FidW-1:0] fid_floor;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_SCAN,
    DP_SHIFT,
    DP_INSERT,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic reject_full;
    logic q_mode;
    logic scan_stop;
    logic scan_hit;
    logic scan_at_end;
    logic shift_last;
    logic out_busy;
  } dp_stat_t;

endpackage

// File: hdl/sktbl_ram.sv
module sktbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sktbl_ctrl.sv
`include "assert_macros.svh"

module sktbl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output sktbl_pkg::dp_cmd_t  cmd,
  input  sktbl_pkg::dp_stat_t stat
);

  import sktbl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_HOLD;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = stat.reject_full ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (stat.scan_stop) begin
          if (stat.q_mode == MODE_REGISTER && !stat.scan_hit) begin
            state_nxt = stat.scan_at_end ? S_INSERT : S_SHIFT;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        cmd.op = DP_SHIFT;
        if (stat.shift_last) begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.op    = DP_INSERT;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.op    = DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `SKT_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == S_IDLE, "controller not idle after reset")
  `SKT_ASSERT(a_shift_exit, state_r == S_SHIFT |=> (state_r == S_SHIFT || state_r == S_INSERT), "shift left without insert")
  `SKT_ASSERT(a_ready_idle, in_ready |-> state_r == S_IDLE, "input taken outside idle")

endmodule

// File: hdl/sktbl_dp.sv
`include "assert_macros.svh"

module sktbl_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_mode,
  input  logic [63:0]                 in_policy_key,
  input  logic                        in_diffusion_permitted,
  input  logic [31:0]                 in_fidelity_floor,
  input  logic [31:0]                 in_request_fidelity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic                        out_key_found,
  output logic                        out_allowed,
  output logic [6:0]                  out_entries_used,
  input  sktbl_pkg::dp_cmd_t          cmd,
  output sktbl_pkg::dp_stat_t         stat
);

  import sktbl_pkg::*;

  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EntryW = $bits(entry_t);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);

  // captured item
  logic             mode_r;
  logic [KeyW-1:0]  key_r;
  logic             permit_r;
  logic [FidW-1:0]  fid_floor_r;
  logic [FidW-1:0]  req_fid_r;

  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;

  logic [StatW-1:0] res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_allowed_r, res_allowed_nxt;

  logic             out_valid_r;
  logic [StatW-1:0] out_status_r;
  logic             out_key_found_r;
  logic             out_allowed_r;
  logic [UsedW-1:0] out_used_r;

  logic [EntryW-1:0] rd_data;
  logic [EntryW-1:0] wr_data;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  entry_t            rd_entry;
  entry_t            new_entry;

  logic scan_at_end, scan_eq, scan_gt, scan_stop, scan_hit;
  logic [CW+UsedW-1:0] used_ext;

  assign rd_entry  = entry_t'(rd_data);
  assign new_entry = '{key: key_r, permit: permit_r, fid_floor: fid_floor_r};

  assign scan_at_end = (ptr_r == count_r);
  assign scan_eq     = (rd_entry.key == key_r);
  assign scan_gt     = (rd_entry.key > key_r);
  assign scan_stop   = scan_at_end || scan_eq || scan_gt;
  assign scan_hit    = !scan_at_end && scan_eq;

  assign stat.reject_full = (in_mode == MODE_REGISTER) && (count_r == DepthC);
  assign stat.q_mode      = mode_r;
  assign stat.scan_stop   = scan_stop;
  assign stat.scan_hit    = scan_hit;
  assign stat.scan_at_end = scan_at_end;
  assign stat.shift_last  = (ptr_r == idx_r);
  assign stat.out_busy    = out_valid_r && !out_ready;

  // table memory: read address follows ptr_nxt so rd_data matches ptr_r
  assign wr_en   = (cmd.op == DP_SHIFT) || (cmd.op == DP_INSERT);
  assign wr_addr = (cmd.op == DP_SHIFT) ? AW'(ptr_r + OneC) : AW'(idx_r);
  assign wr_data = (cmd.op == DP_SHIFT) ? rd_data : EntryW'(new_entry);

  sktbl_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ptr_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    ptr_nxt         = '0;
    idx_nxt         = idx_r;
    count_nxt       = count_r;
    res_status_nxt  = res_status_r;
    res_found_nxt   = res_found_r;
    res_allowed_nxt = res_allowed_r;
    case (cmd.op)
      DP_LOAD: begin
        res_status_nxt  = stat.reject_full ? ST_FULL : ST_OK;
        res_found_nxt   = 1'b0;
        res_allowed_nxt = 1'b0;
      end
      DP_SCAN: begin
        if (!scan_stop) begin
          ptr_nxt = ptr_r + OneC;
        end else begin
          idx_nxt       = ptr_r;
          res_found_nxt = scan_hit;
          if (mode_r == MODE_REGISTER) begin
            if (scan_hit) begin
              res_status_nxt = ST_DUP;
            end else begin
              // start the upward move at the top entry
              ptr_nxt = count_r - OneC;
            end
          end else begin
            res_allowed_nxt = !scan_hit ||
                              (rd_entry.permit && (req_fid_r >= rd_entry.fid_floor));
          end
        end
      end
      DP_SHIFT: begin
        ptr_nxt = ptr_r - OneC;
      end
      DP_INSERT: begin
        count_nxt = count_r + OneC;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      mode_r      <= in_mode;
      key_r       <= in_policy_key;
      permit_r    <= in_diffusion_permitted;
      fid_floor_r <= in_fidelity_floor;
      req_fid_r   <= in_request_fidelity;
    end
    idx_r         <= idx_nxt;
    res_status_r  <= res_status_nxt;
    res_found_r   <= res_found_nxt;
    res_allowed_r <= res_allowed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  assign used_ext = {{UsedW{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_FINISH) begin
      out_status_r    <= res_status_r;
      out_key_found_r <= res_found_r;
      out_allowed_r   <= res_allowed_r;
      out_used_r      <= used_ext[UsedW-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_key_found    = out_key_found_r;
  assign out_allowed      = out_allowed_r;
  assign out_entries_used = out_used_r;

  `SKT_ASSERT(a_count_range, count_r <= DepthC, "entry count beyond table depth")
  `SKT_ASSERT(a_insert_room, cmd.op == DP_INSERT |-> count_r < DepthC, "insert into full table")
  `SKT_ASSERT(a_shift_window, cmd.op == DP_SHIFT |-> (ptr_r >= idx_r && ptr_r < count_r), "shift outside the live range")
  `SKT_ASSERT(a_finish_free, cmd.op == DP_FINISH |-> !(out_valid_r && !out_ready), "result overwrites a pending transfer")

endmodule

// File: hdl/sorted_key_policy_table_top.sv
// Sorted policy table: keeps up to TABLE_DEPTH policies in ascending order of
// their 64-bit key, each with a permit flag and a 32-bit minimum fidelity.
// Input channel (in_valid/in_ready): one transfer is one item. in_mode 0
// registers a policy (ok, table full or duplicate key); in_mode 1 queries a
// key and returns an allow/refuse verdict.
// Output channel (out_valid/out_ready): exactly one result transfer per item,
// in item order, with the entry count after that item.
// Flow: an item walks the table one entry per clock in a single-port
// read / single-port write memory. A query searches up to the position
// where the key is found or would sit; a register searches up to its slot,
// then moves any higher entries up one per clock, then writes; a register
// into a full table skips the search and goes straight to its result. One
// item is in flight at a time.
// The finished result sits in an output register: the next item is taken
// while it waits, and only that item's own result waits for the receiver.
// A stalled receiver therefore holds the block at most one item deep.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// no memory clearing pass is needed, since only live entries are ever read.
module sorted_key_policy_table_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [63:0] in_policy_key,
  input  logic        in_diffusion_permitted,
  input  logic [31:0] in_fidelity_floor,
  input  logic [31:0] in_request_fidelity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_key_found,
  output logic        out_allowed,
  output logic [6:0]  out_entries_used
);

  import sktbl_pkg::*;

  // command from the sequencer, status back from the table datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: accept, search, move up, insert, then hand over the result.
  sktbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Datapath: item capture, walk pointer, entry count, table memory and
  // the output register.
  sktbl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_mode                (in_mode),
    .in_policy_key          (in_policy_key),
    .in_diffusion_permitted (in_diffusion_permitted),
    .in_fidelity_floor      (in_fidelity_floor),
    .in_request_fidelity    (in_request_fidelity),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_key_found          (out_key_found),
    .out_allowed            (out_allowed),
    .out_entries_used       (out_entries_used),
    .cmd                    (cmd),
    .stat                   (stat)
  );

endmodule
